// ===== src/sobel_gradient_direction_core_macros.svh =====
// assertion macros shared by the sobel gradient checker
`ifndef SOBEL_GRADIENT_DIRECTION_CORE_MACROS_SVH
`define SOBEL_GRADIENT_DIRECTION_CORE_MACROS_SVH

// clocked assertion, off while reset is low
`define SGD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check that holds on every cycle a result is offered
`define SGD_ASSERT_OUT(lbl, cond, msg) \
    `SGD_ASSERT_CLK(lbl, m_axis_tvalid |-> (cond), msg)

`endif

// ===== src/sgd_pkg.sv =====
// types and constants shared by the sobel gradient direction core
`default_nettype none

package sgd_pkg;

    localparam int PIX_W = 8;
    localparam int X_W   = 10;
    localparam int Y_W   = 12;
    localparam int G_W   = 11;
    localparam int MAG_W = 11;
    localparam int DIR_W = 2;
    localparam int FW_W  = 11;
    localparam int FH_W  = 13;
    localparam int CFG_W = 13;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    localparam logic [MAG_W-1:0] MAG_MAX = 11'd1442;

    // result bit layout on the output data bus
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + X_W;
    localparam int GX_LSB     = Y_LSB + Y_W;
    localparam int GY_LSB     = GX_LSB + G_W;
    localparam int MAG_LSB    = GY_LSB + G_W;
    localparam int DIR_LSB    = MAG_LSB + MAG_W;
    localparam int OUT_USED_W = DIR_LSB + DIR_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_DATA_W - OUT_USED_W;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    typedef logic [DIR_W-1:0] t_dir;
    localparam t_dir DIR_SECTOR_0 = 2'd0;
    localparam t_dir DIR_SECTOR_1 = 2'd1;
    localparam t_dir DIR_SECTOR_2 = 2'd2;
    localparam t_dir DIR_SECTOR_3 = 2'd3;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             we;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    // [row][col], row 0 is the oldest line, col 0 the leftmost
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_win           win;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

`default_nettype wire

// ===== src/sgd_front.sv =====
// front end: pixel intake, line stores, window and result scheduling
`default_nettype none

module sgd_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sgd_pkg::t_cfg_wr              i_cfg,
    input  wire                           i_pix_valid,
    output logic                          o_pix_ready,
    input  wire  [sgd_pkg::PIX_W-1:0]     i_pix,
    output sgd_pkg::t_push                o_push,
    input  wire                           i_q_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_READ = 4'b0010,
        F_WIN  = 4'b0100,
        F_EMIT = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [sgd_pkg::FW_W-1:0]  r_fw;
    logic [sgd_pkg::FH_W-1:0]  r_fh;
    logic [CW-1:0]             r_c, n_c;
    logic [RW-1:0]             r_r, n_r;
    logic [1:0]                r_k, n_k;
    logic [sgd_pkg::PIX_W-1:0] r_px, r_qa, r_qb;
    sgd_pkg::t_win             r_win;

    logic [sgd_pkg::PIX_W-1:0] mem_a [MAX_WIDTH];
    logic [sgd_pkg::PIX_W-1:0] mem_b [MAX_WIDTH];

    logic                          lastc, lastr;
    logic                          redge, cedge, cond, advance;
    logic [2:0][sgd_pkg::PIX_W-1:0] v;
    sgd_pkg::t_job                 job;

    // a column or row at or past the configured end counts as the last one
    assign lastc = (r_fw == '0) || (32'(r_c) + 32'd1 >= 32'(r_fw))
                || (32'(r_c) + 32'd1 >= 32'(MAX_WIDTH));
    assign lastr = (r_fh == '0) || (32'(r_r) + 32'd1 >= 32'(r_fh))
                || (32'(r_r) + 32'd1 >= 32'(MAX_HEIGHT));

    // first row replicates the incoming pixel upward
    assign v[0] = (r_r == '0) ? r_px : r_qb;
    assign v[1] = (r_r == '0) ? r_px : r_qa;
    assign v[2] = r_px;

    // slot k: bit 1 selects bottom-edge rows, bit 0 right-edge columns
    assign redge   = r_k[1];
    assign cedge   = r_k[0];
    assign cond    = (cedge ? lastc : (r_c != '0)) && (redge ? lastr : (r_r != '0));
    assign advance = (r_state == F_EMIT) && (!cond || !i_q_full);

    always_comb begin
        logic [1:0] ri;
        logic [1:0] cj;
        ri = '0;
        cj = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ri = redge ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
                cj = cedge ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
                job.win[i][j] = r_win[ri][cj];
            end
        end
        job.x    = cedge ? sgd_pkg::X_W'(r_c) : sgd_pkg::X_W'(r_c - 1'b1);
        job.y    = redge ? sgd_pkg::Y_W'(r_r) : sgd_pkg::Y_W'(r_r - 1'b1);
        job.last = redge && cedge;
    end

    assign o_push.valid = (r_state == F_EMIT) && cond && !i_q_full;
    assign o_push.job   = job;
    assign o_pix_ready  = (r_state == F_IDLE);

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_r     = r_r;
        n_k     = r_k;
        unique case (r_state)
            F_IDLE: begin
                if (i_pix_valid) begin
                    n_state = F_READ;
                end
            end
            F_READ: n_state = F_WIN;
            F_WIN: begin
                n_state = F_EMIT;
                n_k     = '0;
            end
            F_EMIT: begin
                if (advance) begin
                    n_k = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_state = F_IDLE;
                        if (lastc) begin
                            n_c = '0;
                            n_r = lastr ? '0 : r_r + RW'(1);
                        end else begin
                            n_c = r_c + CW'(1);
                        end
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_c     <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_fw    <= sgd_pkg::FW_RESET;
            r_fh    <= sgd_pkg::FH_RESET;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            r_k     <= n_k;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    sgd_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg.data[sgd_pkg::FW_W-1:0];
                    sgd_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg.data[sgd_pkg::FH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pix_ready && i_pix_valid) begin
            r_px <= i_pix;
        end
        if (r_state == F_READ) begin
            r_qa <= mem_a[r_c];
            r_qb <= mem_b[r_c];
        end
        if (r_state == F_WIN) begin
            mem_a[r_c] <= r_px;
            mem_b[r_c] <= v[1];
            for (int i = 0; i < 3; i++) begin
                if (r_c == '0) begin
                    r_win[i][0] <= v[i];
                    r_win[i][1] <= v[i];
                end else begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[i][2] <= v[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sgd_queue.sv =====
// short request queue between front end and back end
`default_nettype none

module sgd_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  sgd_pkg::t_push i_push,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_empty,
    output sgd_pkg::t_job  o_head
);

    sgd_pkg::t_job          r_mem [sgd_pkg::QDEPTH];
    logic [sgd_pkg::QPW-1:0] r_wp, r_rp;
    logic [sgd_pkg::QPW:0]   r_cnt;
    logic                    do_push, do_pop;

    assign o_full  = (r_cnt == (sgd_pkg::QPW+1)'(sgd_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

// ===== src/sgd_back.sv =====
// back end: sobel sums, magnitude by bitwise root search, sector, output register
`default_nettype none

module sgd_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_empty,
    input  sgd_pkg::t_job                      i_head,
    output logic                               o_pop,
    output logic                               o_tvalid,
    input  wire                                i_tready,
    output logic [sgd_pkg::OUT_DATA_W-1:0]     o_tdata,
    output logic                               o_tlast
);

    localparam int AW    = sgd_pkg::G_W - 1;
    localparam int SQ_W  = 2 * AW;
    localparam int V_W   = SQ_W + 1;
    localparam int T2_W  = 2 * sgd_pkg::MAG_W;
    localparam int BIT_W = $clog2(sgd_pkg::MAG_W);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_GRAD = 6'b000010,
        B_SQ   = 6'b000100,
        B_SUM  = 6'b001000,
        B_ROOT = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    t_bstate r_state, n_state;

    sgd_pkg::t_job                    r_job;
    logic signed [sgd_pkg::G_W-1:0]   r_gx, r_gy;
    logic [SQ_W-1:0]                  r_sqx, r_sqy;
    logic [V_W-1:0]                   r_v;
    logic [sgd_pkg::MAG_W-1:0]        r_root;
    logic [BIT_W-1:0]                 r_bit;
    sgd_pkg::t_dir                    r_dir;
    logic                             r_ovalid, r_olast;
    logic [sgd_pkg::OUT_DATA_W-1:0]   r_odata;

    logic [AW-1:0]               gx_pos, gx_neg, gy_pos, gy_neg;
    logic [AW-1:0]               ax, ay;
    logic [sgd_pkg::MAG_W-1:0]   t;
    logic [T2_W-1:0]             t_sq;
    sgd_pkg::t_dir               dir;
    logic                        load;

    always_comb begin
        gx_pos = AW'(r_job.win[2][0]) + {r_job.win[2][1], 1'b0} + AW'(r_job.win[2][2]);
        gx_neg = AW'(r_job.win[0][0]) + {r_job.win[0][1], 1'b0} + AW'(r_job.win[0][2]);
        gy_pos = AW'(r_job.win[0][0]) + {r_job.win[1][0], 1'b0} + AW'(r_job.win[2][0]);
        gy_neg = AW'(r_job.win[0][2]) + {r_job.win[1][2], 1'b0} + AW'(r_job.win[2][2]);
    end

    assign ax = r_gx[sgd_pkg::G_W-1] ? AW'(-r_gx) : AW'(r_gx);
    assign ay = r_gy[sgd_pkg::G_W-1] ? AW'(-r_gy) : AW'(r_gy);

    always_comb begin
        if (r_gx == '0) begin
            dir = r_gy[sgd_pkg::G_W-1] ? sgd_pkg::DIR_SECTOR_2 : sgd_pkg::DIR_SECTOR_1;
        end else if (r_gy != '0 && (r_gy[sgd_pkg::G_W-1] != r_gx[sgd_pkg::G_W-1])) begin
            dir = (ay > ax) ? sgd_pkg::DIR_SECTOR_2 : sgd_pkg::DIR_SECTOR_3;
        end else begin
            dir = (ay >= ax) ? sgd_pkg::DIR_SECTOR_1 : sgd_pkg::DIR_SECTOR_0;
        end
    end

    // one root bit per cycle, msb first
    assign t    = r_root | (sgd_pkg::MAG_W'(1) << r_bit);
    assign t_sq = T2_W'(t) * T2_W'(t);

    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign load  = (r_state == B_OUT) && (!r_ovalid || i_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = B_GRAD;
            B_GRAD: n_state = B_SQ;
            B_SQ:   n_state = B_SUM;
            B_SUM:  n_state = B_ROOT;
            B_ROOT: if (r_bit == '0) n_state = B_OUT;
            B_OUT:  if (load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_state == B_GRAD) begin
            r_gx <= sgd_pkg::G_W'($signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg}));
            r_gy <= sgd_pkg::G_W'($signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg}));
        end
        if (r_state == B_SQ) begin
            r_sqx <= SQ_W'(ax) * SQ_W'(ax);
            r_sqy <= SQ_W'(ay) * SQ_W'(ay);
            r_dir <= dir;
        end
        if (r_state == B_SUM) begin
            r_v    <= V_W'(r_sqx) + V_W'(r_sqy);
            r_root <= '0;
            r_bit  <= BIT_W'(sgd_pkg::MAG_W - 1);
        end
        if (r_state == B_ROOT) begin
            if (t_sq <= T2_W'(r_v)) begin
                r_root <= t;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (load) begin
            r_odata <= {sgd_pkg::OUT_PAD'(0), r_dir, r_root, r_gy, r_gx, r_job.y, r_job.x};
            r_olast <= r_job.last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

endmodule

`default_nettype wire

// ===== src/sobel_gradient_direction_core.sv =====
// Sobel 3x3 gradient, magnitude and direction sector over a raster pixel stream
//
// Pixels enter on the s_axis channel in raster order, one 8-bit gray value per
// request. Frame size comes from the config port (index 0 width, index 1 height)
// and is to be written only while the core is idle; the core does not enforce
// this. Reset gives 640 x 480. Results leave on m_axis, one request per described
// pixel, with column, row, both gradient sums, magnitude and sector; tlast marks
// the frame's last result. Results for pixel (x,y) come out once pixel (x+1,y+1)
// has arrived, so output lags one row and one column; right and bottom border
// results follow the pixel that closes them, borders are edge replicated.
// The front end takes a pixel, then runs the line store read, the window update
// and four result slots before it takes the next one. The back end takes one
// result at a time from the queue and runs the gradient sums, the squares, their
// sum, the bitwise square root loop and the output register before it takes the
// next; an interior pixel gives one result and a corner pixel up to four.
// A 4-entry queue sits between the two ends; the output register holds a result
// while m_axis_tready is low, and back pressure fills the queue and then stops
// s_axis_tready. Reset empties the queue and clears counters; the line stores
// need no clearing.
`default_nettype none

module sobel_gradient_direction_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_addr,
    input  wire  [sgd_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel [7:0]
    input  wire  [sgd_pkg::PIX_W-1:0]         s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // out_x, out_y, grad_x, grad_y, magnitude, direction, zero pad
    output logic [sgd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    sgd_pkg::t_cfg_wr cfg;
    sgd_pkg::t_push   push;
    sgd_pkg::t_job    head;
    logic             q_full, q_empty, q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_addr;
    assign cfg.data = i_cfg_data;

    sgd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pix       (s_axis_tdata),
        .o_push      (push),
        .i_q_full    (q_full)
    );

    sgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    sgd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== src/sgd_checker.sv =====
// port level checks for the sobel gradient core, bound to the top level
`default_nettype none
`include "sobel_gradient_direction_core_macros.svh"

module sgd_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [sgd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire                            m_axis_tlast
);

    logic [sgd_pkg::G_W-1:0]   w_gx, w_gy;
    logic [sgd_pkg::MAG_W-1:0] w_mag;
    sgd_pkg::t_dir             w_dir;

    assign w_gx  = m_axis_tdata[sgd_pkg::GX_LSB +: sgd_pkg::G_W];
    assign w_gy  = m_axis_tdata[sgd_pkg::GY_LSB +: sgd_pkg::G_W];
    assign w_mag = m_axis_tdata[sgd_pkg::MAG_LSB +: sgd_pkg::MAG_W];
    assign w_dir = m_axis_tdata[sgd_pkg::DIR_LSB +: sgd_pkg::DIR_W];

    `SGD_ASSERT_CLK(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
    `SGD_ASSERT_CLK(a_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
    `SGD_ASSERT_OUT(a_mag_max, w_mag <= sgd_pkg::MAG_MAX, "magnitude out of range")
    `SGD_ASSERT_OUT(a_mag_zero, (w_mag == '0) == (w_gx == '0 && w_gy == '0), "magnitude zero mismatch")
    `SGD_ASSERT_OUT(a_dir_vert, !(w_gx == '0 && !w_gy[sgd_pkg::G_W-1]) || w_dir == sgd_pkg::DIR_SECTOR_1, "wrong sector for zero grad_x")

endmodule

bind sobel_gradient_direction_core sgd_checker u_sgd_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the sobel gradient direction core: pixel frames checked against a built-in predictor
`timescale 1ns / 100ps

module tb;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 140;
    localparam int LONG_RUN      = 40;

    // pixel content of a frame
    localparam int PAT_RANDOM       = 0;
    localparam int PAT_BINARY       = 1;
    localparam int PAT_NOISE        = 2;
    localparam int PAT_ROW_STEP     = 3;
    localparam int PAT_ROW_STEP_INV = 4;
    localparam int PAT_COL_STEP     = 5;
    localparam int PAT_DIAG         = 6;
    localparam int PAT_FLAT         = 7;

    typedef struct packed {
        logic [sgd_pkg::X_W-1:0]        x;
        logic [sgd_pkg::Y_W-1:0]        y;
        logic signed [sgd_pkg::G_W-1:0] gx;
        logic signed [sgd_pkg::G_W-1:0] gy;
        logic [sgd_pkg::MAG_W-1:0]      mag;
        sgd_pkg::t_dir                  dir;
        logic                           last;
    } t_grad;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    sgd_pkg::t_cfg_idx              i_cfg_addr    = sgd_pkg::CFG_FRAME_WIDTH;
    logic [sgd_pkg::CFG_W-1:0]      i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sgd_pkg::PIX_W-1:0]      s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sgd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    // predictor state
    logic [sgd_pkg::PIX_W-1:0] line_prev  [MAX_W];
    logic [sgd_pkg::PIX_W-1:0] line_prev2 [MAX_W];
    logic [sgd_pkg::PIX_W-1:0] win [3][3];
    int                        col_pos = 0;
    int                        row_pos = 0;
    logic [sgd_pkg::FW_W-1:0]  frame_w_reg = sgd_pkg::FW_RESET;
    logic [sgd_pkg::FH_W-1:0]  frame_h_reg = sgd_pkg::FH_RESET;
    t_grad                     gradient_q [$];

    int mismatches   = 0;
    int stall_cycles = 0;
    int src_left     = 0;
    bit src_calm     = 1'b0;
    int snk_left     = 0;
    bit snk_calm     = 1'b0;

    sobel_gradient_direction_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic int eff_size(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int isqrt(int v);
        int r;
        int t;
        r = 0;
        for (int b = 11; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // window row or column for a tap, replicating the last one on a border
    function automatic int win_idx(int i, bit clip);
        if (!clip) return i;
        return (i == 0) ? 1 : 2;
    endfunction

    task automatic push_gradient(int x, int y, bit clip_row, bit clip_col, bit last);
        int    p [3][3];
        int    gx;
        int    gy;
        int    ax;
        int    ay;
        t_grad g;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = int'(win[win_idx(i, clip_row)][win_idx(j, clip_col)]);
        gx = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        gy = (p[0][0] + 2 * p[1][0] + p[2][0]) - (p[0][2] + 2 * p[1][2] + p[2][2]);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        g.x    = sgd_pkg::X_W'(x);
        g.y    = sgd_pkg::Y_W'(y);
        g.gx   = sgd_pkg::G_W'(gx);
        g.gy   = sgd_pkg::G_W'(gy);
        g.mag  = sgd_pkg::MAG_W'(isqrt(ax * ax + ay * ay));
        g.last = last;
        if (gx == 0)
            g.dir = (gy < 0) ? sgd_pkg::DIR_SECTOR_2 : sgd_pkg::DIR_SECTOR_1;
        else if (gy != 0 && ((gy < 0) != (gx < 0)))
            g.dir = (ay > ax) ? sgd_pkg::DIR_SECTOR_2 : sgd_pkg::DIR_SECTOR_3;
        else
            g.dir = (ay >= ax) ? sgd_pkg::DIR_SECTOR_1 : sgd_pkg::DIR_SECTOR_0;
        gradient_q.push_back(g);
    endtask

    task automatic sobel_predict(logic [sgd_pkg::PIX_W-1:0] px);
        int                        w;
        int                        h;
        int                        c;
        int                        r;
        bit                        lastc;
        bit                        lastr;
        logic [sgd_pkg::PIX_W-1:0] top;
        logic [sgd_pkg::PIX_W-1:0] mid;
        logic [sgd_pkg::PIX_W-1:0] v;
        w = eff_size(int'(frame_w_reg), MAX_W);
        h = eff_size(int'(frame_h_reg), MAX_H);
        c = col_pos % MAX_W;
        r = row_pos;
        lastc = (c + 1 >= w);
        lastr = (r + 1 >= h);
        if (r == 0) begin
            top = px;
            mid = px;
            line_prev2[c] = px;
        end else begin
            top = line_prev2[c];
            mid = line_prev[c];
            line_prev2[c] = mid;
        end
        line_prev[c] = px;
        for (int i = 0; i < 3; i++) begin
            v = (i == 0) ? top : (i == 1) ? mid : px;
            if (c == 0) begin
                win[i][0] = v;
                win[i][1] = v;
            end else begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[i][2] = v;
        end
        if (c >= 1 && r >= 1) push_gradient(c - 1, r - 1, 1'b0, 1'b0, 1'b0);
        if (lastc && r >= 1) push_gradient(c, r - 1, 1'b0, 1'b1, 1'b0);
        if (lastr) begin
            if (c >= 1) push_gradient(c - 1, r, 1'b1, 1'b0, 1'b0);
            if (lastc) push_gradient(c, r, 1'b1, 1'b1, 1'b1);
        end
        if (lastc) begin
            col_pos = 0;
            row_pos = lastr ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic logic [sgd_pkg::PIX_W-1:0] pattern_pixel(int pat, int x, int y);
        case (pat)
            PAT_ROW_STEP:     return (y >= 1) ? 8'hFF : 8'h00;
            PAT_ROW_STEP_INV: return (y >= 1) ? 8'h00 : 8'hFF;
            PAT_COL_STEP:     return (x >= 2) ? 8'hFF : 8'h00;
            PAT_DIAG:         return (x > y) ? 8'hFF : 8'h00;
            PAT_FLAT:         return 8'd128;
            PAT_BINARY:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            PAT_NOISE:        return sgd_pkg::PIX_W'(96 + $urandom_range(0, 15));
            default:          return sgd_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // per-request wait, with stretches where a side never idles
    task automatic draw_wait(inout int left, inout bit calm, output int w);
        if (left == 0) begin
            left = $urandom_range(8, 40);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        w = calm ? 0 : $urandom_range(0, 14);
    endtask

    task automatic send_pixel(logic [sgd_pkg::PIX_W-1:0] px);
        int gap;
        draw_wait(src_left, src_calm, gap);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = px;
        do @(posedge i_clk); while (!s_axis_tready);
        sobel_predict(px);
    endtask

    task automatic send_until_frame_end(int pat, output int sent);
        sent = 0;
        do begin
            send_pixel(pattern_pixel(pat, col_pos, row_pos));
            sent++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // all results drained, then time for a pixel that gives none
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (gradient_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(sgd_pkg::t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = sgd_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == sgd_pkg::CFG_FRAME_WIDTH)
            frame_w_reg = sgd_pkg::FW_W'(value);
        else
            frame_h_reg = sgd_pkg::FH_W'(value);
    endtask

    task automatic set_frame(int w, int h);
        settle();
        write_reg(sgd_pkg::CFG_FRAME_WIDTH, w);
        write_reg(sgd_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // start under the reset size, then shrink it mid row so the row closes early
    task automatic test_reset_size();
        int n;
        repeat (5) send_pixel(pattern_pixel(PAT_RANDOM, col_pos, row_pos));
        set_frame(3, 4);
        send_until_frame_end(PAT_RANDOM, n);
    endtask

    task automatic test_gradient_extremes();
        int n;
        set_frame(3, 2);
        send_until_frame_end(PAT_ROW_STEP, n);
        send_until_frame_end(PAT_ROW_STEP_INV, n);
        send_until_frame_end(PAT_COL_STEP, n);
        send_until_frame_end(PAT_DIAG, n);
        send_until_frame_end(PAT_FLAT, n);
    endtask

    task automatic test_degenerate_sizes();
        int n;
        set_frame(0, 0);
        send_until_frame_end(PAT_RANDOM, n);
        set_frame(1, 3);
        send_until_frame_end(PAT_BINARY, n);
        set_frame(3, 1);
        send_until_frame_end(PAT_RANDOM, n);
    endtask

    // oversized width register, then a narrow width closes the running row
    task automatic test_widest_row();
        int n;
        set_frame(2047, 1);
        repeat (LONG_RUN) send_pixel(pattern_pixel(PAT_RANDOM, col_pos, row_pos));
        settle();
        write_reg(sgd_pkg::CFG_FRAME_WIDTH, 3);
        send_until_frame_end(PAT_RANDOM, n);
    endtask

    // oversized height register, then a short height closes the running column
    task automatic test_tallest_column();
        int n;
        set_frame(1, 8191);
        repeat (LONG_RUN) send_pixel(pattern_pixel(PAT_RANDOM, col_pos, row_pos));
        settle();
        write_reg(sgd_pkg::CFG_FRAME_HEIGHT, 3);
        send_until_frame_end(PAT_RANDOM, n);
    endtask

    task automatic test_random_frames();
        int sent;
        int n;
        int w;
        int h;
        int pat;
        int cut;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 8);
            h = $urandom_range(2, 6);
            case ($urandom_range(0, 5))
                0:       pat = PAT_BINARY;
                1:       pat = PAT_NOISE;
                2:       pat = PAT_DIAG;
                default: pat = PAT_RANDOM;
            endcase
            set_frame(w, h);
            if ($urandom_range(0, 3) == 0) begin
                // resize mid frame; width never grows so no unwritten line entry is read
                cut = $urandom_range(1, w * h - 1);
                repeat (cut) send_pixel(pattern_pixel(pat, col_pos, row_pos));
                sent += cut;
                settle();
                if ($urandom_range(0, 1) != 0)
                    write_reg(sgd_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, 8));
                else
                    write_reg(sgd_pkg::CFG_FRAME_WIDTH, $urandom_range(1, w));
            end
            send_until_frame_end(pat, n);
            sent += n;
        end
    endtask

    initial begin : result_sink
        int w;
        forever begin
            draw_wait(snk_left, snk_calm, w);
            repeat (w) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    always @(posedge i_clk) begin : gradient_check
        t_grad got;
        t_grad want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x    = m_axis_tdata[sgd_pkg::X_LSB +: sgd_pkg::X_W];
            got.y    = m_axis_tdata[sgd_pkg::Y_LSB +: sgd_pkg::Y_W];
            got.gx   = m_axis_tdata[sgd_pkg::GX_LSB +: sgd_pkg::G_W];
            got.gy   = m_axis_tdata[sgd_pkg::GY_LSB +: sgd_pkg::G_W];
            got.mag  = m_axis_tdata[sgd_pkg::MAG_LSB +: sgd_pkg::MAG_W];
            got.dir  = m_axis_tdata[sgd_pkg::DIR_LSB +: sgd_pkg::DIR_W];
            got.last = m_axis_tlast;
            if (gradient_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d gx=%0d gy=%0d mag=%0d dir=%0d last=%0d",
                             got.x, got.y, got.gx, got.gy, got.mag, got.dir, got.last);
            end else begin
                want = gradient_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp x=%0d y=%0d gx=%0d gy=%0d mag=%0d dir=%0d last=%0d",
                                 want.x, want.y, want.gx, want.gy, want.mag, want.dir,
                                 want.last);
                        $display("         got x=%0d y=%0d gx=%0d gy=%0d mag=%0d dir=%0d last=%0d",
                                 got.x, got.y, got.gx, got.gy, got.mag, got.dir, got.last);
                    end
                end
            end
        end
    end

    // ends a hung run: cycles in a row with no request moved and no register write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_size();
        test_gradient_extremes();
        test_degenerate_sizes();
        test_widest_row();
        test_tallest_column();
        test_random_frames();

        settle();
        mismatches += gradient_q.size();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
